// ===== design/gcr_pkg.sv =====
package gcr_pkg;

  localparam int IMAGE_DIM_MAX = 8192;
  localparam int COORD_W = 13;
  localparam int DIM_W = 14;
  localparam int GAMMA_W = 16;
  localparam int CHAN_W = 8;
  localparam int LOG_W = 19;
  localparam int LANE_DEPTH = 12;

  localparam logic [2:0] REG_GAMMA = 3'd0;
  localparam logic [2:0] REG_ROI_X_FIRST = 3'd1;
  localparam logic [2:0] REG_ROI_X_LAST = 3'd2;
  localparam logic [2:0] REG_ROI_Y_FIRST = 3'd3;
  localparam logic [2:0] REG_ROI_Y_LAST = 3'd4;
  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd5;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd6;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd7;

  typedef struct packed {
    logic active;
    logic corr;
  } gcr_mode_t;

  typedef struct packed {
    logic fixed;
    logic [CHAN_W-1:0] fval;
    logic [2:0] q3;
  } gcr_side_t;

  typedef logic [31:0] ck_arr_t [17];
  typedef logic [LOG_W-1:0] d_arr_t [256];
  typedef logic [32:0] p_arr_t [256];

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xv;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    xv = x;
    for (int i = 0; i < 32; i++) begin
      if (xv >= r + b) begin
        xv = xv - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic ck_arr_t build_ck();
    ck_arr_t c;
    logic [63:0] t;
    t = 64'h8000_0000;
    c[0] = 32'h8000_0000;
    for (int k = 1; k <= 16; k++) begin
      t = isqrt64({t[31:0], 32'h0});
      c[k] = t[31:0];
    end
    return c;
  endfunction

  function automatic logic [LOG_W-1:0] log2_q16(input logic [7:0] n);
    logic [2:0] k;
    logic [15:0] frac;
    logic [63:0] m;
    k = '0;
    frac = '0;
    for (int i = 0; i < 8; i++) begin
      if (n[i]) begin
        k = 3'(i);
      end
    end
    m = {56'h0, n} << (30 - int'(k));
    for (int i = 1; i <= 16; i++) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[16-i] = 1'b1;
      end
    end
    return {k, frac};
  endfunction

  function automatic d_arr_t build_d();
    d_arr_t d;
    logic [LOG_W-1:0] lf;
    logic [LOG_W-1:0] lv;
    lf = log2_q16(8'd255);
    for (int v = 0; v < 256; v++) begin
      lv = log2_q16(8'(v));
      d[v] = (lf > lv) ? lf - lv : '0;
    end
    return d;
  endfunction

  function automatic p_arr_t build_t1(input ck_arr_t c);
    p_arr_t t;
    logic [63:0] p;
    logic [7:0] h;
    for (int j = 0; j < 256; j++) begin
      h = 8'(j);
      p = 64'h1_0000_0000;
      for (int k = 1; k <= 8; k++) begin
        if (h[8-k]) begin
          p = (p * {32'h0, c[k]}) >> 32;
        end
      end
      t[j] = p[32:0];
    end
    return t;
  endfunction

  localparam ck_arr_t CK = build_ck();
  localparam d_arr_t DLOG = build_d();
  localparam p_arr_t T1 = build_t1(CK);

endpackage

// ===== design/gamma_correct_roi_pixel.sv =====
// Gamma correction of one pixel per clock. A pixel is accepted at every
// cycle with start high (busy is held low), and its result appears with a
// one-cycle done strobe after passing one input stage, the log2 table,
// the exponent multiply, the exp2 table for the upper fraction bits, eight
// stages of the exp2 multiplier chain and the final scale. Pixels outside
// both the region and the image give no strobe. Results cannot be held off
// and must be taken when shown.
module gamma_correct_roi_pixel (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          wr_en,
  input  logic [2:0]                    wr_index,
  input  logic [gcr_pkg::GAMMA_W-1:0]   wr_data,
  input  logic [gcr_pkg::COORD_W-1:0]   x_pos,
  input  logic [gcr_pkg::COORD_W-1:0]   y_pos,
  input  logic [gcr_pkg::CHAN_W-1:0]    in_chan0,
  input  logic [gcr_pkg::CHAN_W-1:0]    in_chan1,
  input  logic [gcr_pkg::CHAN_W-1:0]    in_chan2,
  output logic                          done,
  output logic [gcr_pkg::CHAN_W-1:0]    out_chan0,
  output logic [gcr_pkg::CHAN_W-1:0]    out_chan1,
  output logic [gcr_pkg::CHAN_W-1:0]    out_chan2,
  output logic                          was_corrected
);

  logic [gcr_pkg::GAMMA_W-1:0] gamma_q4_12;
  logic [gcr_pkg::COORD_W-1:0] roi_x_first;
  logic [gcr_pkg::COORD_W-1:0] roi_x_last;
  logic [gcr_pkg::COORD_W-1:0] roi_y_first;
  logic [gcr_pkg::COORD_W-1:0] roi_y_last;
  logic [gcr_pkg::DIM_W-1:0] image_width;
  logic [gcr_pkg::DIM_W-1:0] image_height;
  logic [1:0] channel_count;

  logic in_roi;
  logic in_img;
  logic vld0;
  logic roi0;
  logic [gcr_pkg::CHAN_W-1:0] v0 [3];
  gcr_pkg::gcr_mode_t mode0 [3];
  logic [gcr_pkg::LANE_DEPTH-1:0] vld_pipe;
  logic [gcr_pkg::LANE_DEPTH-1:0] roi_pipe;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_q4_12 <= 16'd4096;
      roi_x_first <= '0;
      roi_x_last <= gcr_pkg::COORD_W'(gcr_pkg::IMAGE_DIM_MAX - 1);
      roi_y_first <= '0;
      roi_y_last <= gcr_pkg::COORD_W'(gcr_pkg::IMAGE_DIM_MAX - 1);
      image_width <= gcr_pkg::DIM_W'(gcr_pkg::IMAGE_DIM_MAX);
      image_height <= gcr_pkg::DIM_W'(gcr_pkg::IMAGE_DIM_MAX);
      channel_count <= 2'd3;
    end else if (wr_en) begin
      unique case (wr_index)
        gcr_pkg::REG_GAMMA:         gamma_q4_12 <= wr_data;
        gcr_pkg::REG_ROI_X_FIRST:   roi_x_first <= wr_data[gcr_pkg::COORD_W-1:0];
        gcr_pkg::REG_ROI_X_LAST:    roi_x_last <= wr_data[gcr_pkg::COORD_W-1:0];
        gcr_pkg::REG_ROI_Y_FIRST:   roi_y_first <= wr_data[gcr_pkg::COORD_W-1:0];
        gcr_pkg::REG_ROI_Y_LAST:    roi_y_last <= wr_data[gcr_pkg::COORD_W-1:0];
        gcr_pkg::REG_IMAGE_WIDTH:   image_width <= wr_data[gcr_pkg::DIM_W-1:0];
        gcr_pkg::REG_IMAGE_HEIGHT:  image_height <= wr_data[gcr_pkg::DIM_W-1:0];
        gcr_pkg::REG_CHANNEL_COUNT: channel_count <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  assign in_roi = (x_pos >= roi_x_first) && (x_pos <= roi_x_last) &&
                  (y_pos >= roi_y_first) && (y_pos <= roi_y_last);
  assign in_img = ({1'b0, x_pos} < image_width) && ({1'b0, y_pos} < image_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else begin
      vld0 <= start && !busy && (in_roi || in_img);
    end
  end

  always_ff @(posedge clk) begin
    roi0 <= in_roi;
    v0[0] <= in_chan0;
    v0[1] <= in_chan1;
    v0[2] <= in_chan2;
    for (int i = 0; i < 3; i++) begin
      mode0[i].active <= 2'(i) < channel_count;
      mode0[i].corr <= in_roi;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [gcr_pkg::CHAN_W-1:0] res;
    gcr_lane u_lane (
      .clk   (clk),
      .v     (v0[i]),
      .gamma (gamma_q4_12),
      .mode  (mode0[i]),
      .res   (res)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else begin
      vld_pipe <= {vld_pipe[gcr_pkg::LANE_DEPTH-2:0], vld0};
    end
  end

  always_ff @(posedge clk) begin
    roi_pipe <= {roi_pipe[gcr_pkg::LANE_DEPTH-2:0], roi0};
  end

  assign done = vld_pipe[gcr_pkg::LANE_DEPTH-1];
  assign was_corrected = roi_pipe[gcr_pkg::LANE_DEPTH-1];
  assign out_chan0 = g_lane[0].res;
  assign out_chan1 = g_lane[1].res;
  assign out_chan2 = g_lane[2].res;

`ifndef SYNTH
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, gcr_pkg::LANE_DEPTH + 1))
    else $error("item out without item in");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("item out after reset");

  a_roi_tracks: assert property (@(posedge clk) disable iff (rst)
    done |-> was_corrected == $past(roi0, gcr_pkg::LANE_DEPTH))
    else $error("region flag lost in pipe");
`endif

endmodule

// ===== design/gcr_lane.sv =====
module gcr_lane (
  input  logic                         clk,
  input  logic [gcr_pkg::CHAN_W-1:0]   v,
  input  logic [gcr_pkg::GAMMA_W-1:0]  gamma,
  input  gcr_pkg::gcr_mode_t           mode,
  output logic [gcr_pkg::CHAN_W-1:0]   res
);

  gcr_pkg::gcr_side_t side1;
  gcr_pkg::gcr_side_t side1_next;
  logic [gcr_pkg::LOG_W-1:0] d1;
  logic [gcr_pkg::GAMMA_W-1:0] g1;
  gcr_pkg::gcr_side_t side2;
  logic [34:0] e2;
  logic [6:0] q;
  logic [15:0] f;
  gcr_pkg::gcr_side_t side_s [9];
  logic [32:0] p_s [9];
  logic [7:0] fl_s [9];
  logic [40:0] scaled;

  // early outs: inactive, pass-through, zero and full samples
  always_comb begin
    side1_next = '0;
    if (!mode.active) begin
      side1_next.fixed = 1'b1;
    end else if (!mode.corr) begin
      side1_next.fixed = 1'b1;
      side1_next.fval = v;
    end else if (v == 8'd0) begin
      side1_next.fixed = 1'b1;
      side1_next.fval = (gamma == '0) ? 8'd255 : 8'd0;
    end else if (v == 8'd255) begin
      side1_next.fixed = 1'b1;
      side1_next.fval = 8'd255;
    end
  end

  always_ff @(posedge clk) begin
    side1 <= side1_next;
    d1 <= gcr_pkg::DLOG[v];
    g1 <= gamma;
  end

  always_ff @(posedge clk) begin
    side2 <= side1;
    e2 <= 35'(d1) * 35'(g1);
  end

  assign q = e2[34:28];
  assign f = e2[27:12];

  always_ff @(posedge clk) begin
    side_s[0].fixed <= side2.fixed | (q[6:3] != 4'd0);
    side_s[0].fval <= side2.fixed ? side2.fval : 8'd0;
    side_s[0].q3 <= q[2:0];
    p_s[0] <= gcr_pkg::T1[f[15:8]];
    fl_s[0] <= f[7:0];
  end

  // exp2 of the low fraction bits, one constant multiply per stage
  for (genvar i = 0; i < 8; i++) begin : g_exp
    logic [64:0] prod;
    assign prod = 65'(p_s[i]) * 65'(gcr_pkg::CK[9+i]);
    always_ff @(posedge clk) begin
      side_s[i+1] <= side_s[i];
      fl_s[i+1] <= fl_s[i];
      p_s[i+1] <= fl_s[i][7-i] ? prod[64:32] : p_s[i];
    end
  end

  assign scaled = 41'(p_s[8]) * 41'd255;

  always_ff @(posedge clk) begin
    res <= side_s[8].fixed ? side_s[8].fval : 8'(scaled >> (32 + int'(side_s[8].q3)));
  end

endmodule

// ===== sim/tb_gamma_correct_roi_pixel.sv =====
`timescale 1ns / 1ps

module tb_gamma_correct_roi_pixel;

  typedef struct packed {
    logic [gcr_pkg::COORD_W-1:0] x;
    logic [gcr_pkg::COORD_W-1:0] y;
    logic [gcr_pkg::CHAN_W-1:0] c0;
    logic [gcr_pkg::CHAN_W-1:0] c1;
    logic [gcr_pkg::CHAN_W-1:0] c2;
  } pixel_t;

  typedef struct packed {
    logic [gcr_pkg::CHAN_W-1:0] c0;
    logic [gcr_pkg::CHAN_W-1:0] c1;
    logic [gcr_pkg::CHAN_W-1:0] c2;
    logic corr;
  } graded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = gcr_pkg::REG_GAMMA;
  logic [gcr_pkg::GAMMA_W-1:0] wr_data = '0;
  logic [gcr_pkg::COORD_W-1:0] x_pos = '0;
  logic [gcr_pkg::COORD_W-1:0] y_pos = '0;
  logic [gcr_pkg::CHAN_W-1:0] in_chan0 = '0;
  logic [gcr_pkg::CHAN_W-1:0] in_chan1 = '0;
  logic [gcr_pkg::CHAN_W-1:0] in_chan2 = '0;
  logic done;
  logic [gcr_pkg::CHAN_W-1:0] out_chan0;
  logic [gcr_pkg::CHAN_W-1:0] out_chan1;
  logic [gcr_pkg::CHAN_W-1:0] out_chan2;
  logic was_corrected;

  gamma_correct_roi_pixel dut (.*);

  always #4 clk = ~clk;

  logic [15:0] gamma_r;
  logic [12:0] rx0, rx1, ry0, ry1;
  logic [13:0] img_w, img_h;
  logic [1:0] nchan;
  logic [63:0] root_tab [17];

  pixel_t pending_q [$];
  graded_t graded_q [$];
  int errors = 0;
  int n_graded = 0;
  int n_corr = 0;
  int gap_left = 0;
  int burst_left = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] a);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [18:0] log_fix(logic [7:0] n);
    logic [2:0] k;
    logic [15:0] fr;
    logic [63:0] m;
    k = 0;
    fr = 0;
    while (k < 7 && (n >> (k + 1)) != 0) k++;
    m = 64'(n) << (30 - k);
    for (int i = 1; i <= 16; i++) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        fr[16-i] = 1'b1;
      end
    end
    return {k, fr};
  endfunction

  function automatic logic [7:0] tone_map(logic [7:0] v, logic [15:0] g);
    logic [18:0] lf, lv, d;
    logic [63:0] e, p;
    logic [15:0] f;
    int q;
    if (v == 0) return (g == 0) ? 8'd255 : 8'd0;
    if (v == 8'd255) return 8'd255;
    lf = log_fix(8'd255);
    lv = log_fix(v);
    d = (lf > lv) ? lf - lv : '0;
    e = (64'(d) * 64'(g)) >> 12;
    q = int'(e >> 16);
    if (q >= 8) return 8'd0;
    f = e[15:0];
    p = 64'h1_0000_0000;
    for (int k = 1; k <= 16; k++)
      if (f[16-k]) p = (p * root_tab[k]) >> 32;
    return 8'((64'd255 * p) >> (32 + q));
  endfunction

  task automatic grade_pixel(pixel_t px);
    logic in_roi, in_img;
    graded_t r;
    in_roi = px.x >= rx0 && px.x <= rx1 && px.y >= ry0 && px.y <= ry1;
    in_img = 14'(px.x) < img_w && 14'(px.y) < img_h;
    if (!in_roi && !in_img) return;
    r.c0 = nchan >= 1 ? (in_roi ? tone_map(px.c0, gamma_r) : px.c0) : '0;
    r.c1 = nchan >= 2 ? (in_roi ? tone_map(px.c1, gamma_r) : px.c1) : '0;
    r.c2 = nchan >= 3 ? (in_roi ? tone_map(px.c2, gamma_r) : px.c2) : '0;
    r.corr = in_roi;
    graded_q.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (start) grade_pixel({x_pos, y_pos, in_chan0, in_chan1, in_chan2});
      if (pending_q.size() > 0 && gap_left == 0) begin
        pixel_t px;
        px = pending_q.pop_front();
        {x_pos, y_pos, in_chan0, in_chan1, in_chan2} <= px;
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
          gap_left = burst_left == 0 ? 0 : $urandom_range(1, 6);
        end
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (graded_q.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %b", $time, out_chan0, out_chan1,
                 out_chan2, was_corrected);
        errors++;
      end else begin
        graded_t w;
        w = graded_q.pop_front();
        n_graded++;
        if (w.corr) n_corr++;
        if (out_chan0 !== w.c0 || out_chan1 !== w.c1 || out_chan2 !== w.c2 ||
            was_corrected !== w.corr) begin
          $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b", $time,
                   w.c0, w.c1, w.c2, w.corr, out_chan0, out_chan1, out_chan2,
                   was_corrected);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      gcr_pkg::REG_GAMMA: gamma_r = val;
      gcr_pkg::REG_ROI_X_FIRST: rx0 = val[12:0];
      gcr_pkg::REG_ROI_X_LAST: rx1 = val[12:0];
      gcr_pkg::REG_ROI_Y_FIRST: ry0 = val[12:0];
      gcr_pkg::REG_ROI_Y_LAST: ry1 = val[12:0];
      gcr_pkg::REG_IMAGE_WIDTH: img_w = val[13:0];
      gcr_pkg::REG_IMAGE_HEIGHT: img_h = val[13:0];
      default: nchan = val[1:0];
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || start || graded_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel(int w, int h);
    pixel_t px;
    px.x = ($urandom_range(0, 4) == 0) ? 13'($urandom) : 13'($urandom_range(0, w));
    px.y = ($urandom_range(0, 4) == 0) ? 13'($urandom) : 13'($urandom_range(0, h));
    px.c0 = 8'($urandom);
    px.c1 = 8'($urandom);
    px.c2 = 8'($urandom);
    return px;
  endfunction

  task automatic config_phase(logic [15:0] g, int x0, int x1, int y0, int y1,
                              int w, int h, int nc);
    write_reg(gcr_pkg::REG_GAMMA, g);
    write_reg(gcr_pkg::REG_ROI_X_FIRST, 16'(x0));
    write_reg(gcr_pkg::REG_ROI_X_LAST, 16'(x1));
    write_reg(gcr_pkg::REG_ROI_Y_FIRST, 16'(y0));
    write_reg(gcr_pkg::REG_ROI_Y_LAST, 16'(y1));
    write_reg(gcr_pkg::REG_IMAGE_WIDTH, 16'(w));
    write_reg(gcr_pkg::REG_IMAGE_HEIGHT, 16'(h));
    write_reg(gcr_pkg::REG_CHANNEL_COUNT, 16'(nc));
  endtask

  initial begin
    root_tab[0] = 64'h8000_0000;
    for (int k = 1; k <= 16; k++) root_tab[k] = int_sqrt(root_tab[k-1] << 32);
    gamma_r = 16'd4096;
    rx0 = 0; rx1 = 13'h1FFF; ry0 = 0; ry1 = 13'h1FFF;
    img_w = 14'd8192; img_h = 14'd8192; nchan = 2'd3;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed items at reset settings
    pending_q.push_back({13'd0, 13'd0, 8'd0, 8'd255, 8'd1});
    pending_q.push_back({13'h1FFF, 13'h1FFF, 8'd128, 8'd254, 8'd64});
    pending_q.push_back({13'h1555, 13'h0AAA, 8'h55, 8'hAA, 8'hFF});
    drain();
    config_phase(16'd0, 2, 5, 2, 5, 8, 8, 3);
    pending_q.push_back({13'd3, 13'd3, 8'd0, 8'd100, 8'd255});
    pending_q.push_back({13'd7, 13'd7, 8'd9, 8'd10, 8'd11});
    pending_q.push_back({13'd8, 13'd0, 8'd9, 8'd10, 8'd11});
    pending_q.push_back({13'd0, 13'd8, 8'd9, 8'd10, 8'd11});
    drain();
    config_phase(16'hFFFF, 100, 10, 0, 20, 50, 50, 1);
    pending_q.push_back({13'd50, 13'd5, 8'd200, 8'd1, 8'd2});
    pending_q.push_back({13'd49, 13'd49, 8'd254, 8'd1, 8'd2});
    drain();
    config_phase(16'd1, 8000, 8191, 8000, 8191, 0, 100, 0);
    pending_q.push_back({13'd8191, 13'd8191, 8'd1, 8'd254, 8'd128});
    pending_q.push_back({13'd5, 13'd5, 8'd1, 8'd2, 8'd3});
    drain();
    config_phase(16'd2048, 0, 63, 0, 63, 16383, 16383, 2);
    pending_q.push_back({13'd10, 13'd10, 8'd1, 8'd254, 8'd3});
    pending_q.push_back({13'd64, 13'd64, 8'd1, 8'd254, 8'd3});
    drain();

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      int w, h;
      logic [15:0] g;
      w = $urandom_range(1, 300);
      h = $urandom_range(1, 300);
      case (ph % 4)
        0: g = 16'($urandom);
        1: g = 16'($urandom_range(0, 16384));
        2: g = 16'($urandom_range(2048, 8192));
        default: g = (ph < 4) ? 16'd0 : 16'hFFFF;
      endcase
      config_phase(g, $urandom_range(0, w), $urandom_range(0, w + 20),
                   $urandom_range(0, h), $urandom_range(0, h + 20),
                   (ph == 9) ? 8192 : w, (ph == 9) ? 8192 : h, $urandom_range(0, 3));
      for (int i = 0; i < 110; i++) pending_q.push_back(rand_pixel(w + 10, h + 10));
      drain();
    end

    $display("covered %0d results, %0d corrected, over directed and 10 random setups",
             n_graded, n_corr);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
design/gcr_pkg.sv
design/gcr_lane.sv
design/gamma_correct_roi_pixel.sv
sim/tb_gamma_correct_roi_pixel.sv
